[hdl/p24rt_pkg.sv]
// Shared types and constants for the /24 prefix route hash table.
package p24rt_pkg;

  localparam int BUCKETS_DEF     = 1024;
  localparam int MAX_ENTRIES_DEF = 256;

  localparam int OCTET_W = 8;
  localparam int KEY_W   = 3 * OCTET_W;
  localparam int ROUTE_W = 16;
  localparam int SUM_W   = 10;
  localparam int STAT_W  = 3;

  typedef enum logic [0:0] {
    CMD_INSERT = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_MATCH    = 3'd0,
    STAT_DEFAULT  = 3'd1,
    STAT_NOROUTE  = 3'd2,
    STAT_INSERTED = 3'd3,
    STAT_FULL     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_WALK
  } state_t;

  typedef struct packed {
    logic               cmd;
    logic [OCTET_W-1:0] octet_a;
    logic [OCTET_W-1:0] octet_b;
    logic [OCTET_W-1:0] octet_c;
    logic [ROUTE_W-1:0] route_value;
  } req_word_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [ROUTE_W-1:0] route_out;
  } rsp_word_t;

endpackage

[hdl/p24rt_req_if.sv]
// Request channel: valid/ready handshake carrying one command word.
interface p24rt_req_if;
  import p24rt_pkg::*;

  logic      valid;
  logic      ready;
  req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/p24rt_rsp_if.sv]
// Response channel: valid/ready handshake carrying one result word.
interface p24rt_rsp_if;
  import p24rt_pkg::*;

  logic      valid;
  logic      ready;
  rsp_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/prefix24_route_hash_table_unit.sv]
// Top level of the /24 prefix route hash table.
//
// Channels: req takes one command word (insert or lookup of a three-octet
// prefix), rsp returns exactly one result word per command, in order.
// An insert pushes a new entry onto the head of the chain picked by the
// octet sum, unless the pool is full; prefix 0.0.0 also sets the default
// route. A lookup walks that chain, newest entry first, and returns the
// first exact match, else the default route, else no route.
// Timing: one word at a time; a new word is accepted only after the last
// has finished. An insert finishes in the head state once the output
// register is free; a lookup then walks the chain, one entry memory read
// per cycle, until a match or the end of the chain.
// Reset: the head memory is swept to empty, one bucket a cycle, and req
// stays not ready until the sweep has finished.
// Stall: the result sits in an output register; the next word is still
// accepted, and finishing it waits until rsp takes the held result.
module prefix24_route_hash_table_unit #(
  parameter int BUCKETS     = p24rt_pkg::BUCKETS_DEF,
  parameter int MAX_ENTRIES = p24rt_pkg::MAX_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst,
  p24rt_req_if.sink    req,
  p24rt_rsp_if.source  rsp
);
  import p24rt_pkg::*;

  localparam int BW = $clog2(BUCKETS);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int UW = $clog2(MAX_ENTRIES + 1);
  localparam int EW = KEY_W + ROUTE_W + 1 + IW;

  state_t state, state_next;

  logic               item_lookup;
  logic [KEY_W-1:0]   item_key;
  logic [ROUTE_W-1:0] item_value;
  logic [BW-1:0]      item_bucket;

  logic [UW-1:0]      used;
  logic [ROUTE_W-1:0] default_route;
  logic               default_valid;

  logic               out_valid;
  status_t            out_status;
  logic [ROUTE_W-1:0] out_route;

  logic [SUM_W-1:0]   req_sum;
  logic [BW-1:0]      req_bucket;
  logic               accept;
  logic               out_free;
  logic               pool_full;

  logic               clearing;
  logic [IW:0]        head_rd_data;
  logic               head_valid;
  logic [IW-1:0]      head_idx;
  logic [EW-1:0]      ent_rd_data;
  logic [KEY_W-1:0]   ent_key;
  logic [ROUTE_W-1:0] ent_value;
  logic               ent_link_valid;
  logic [IW-1:0]      ent_link_idx;
  logic               walk_hit;

  logic               ready_c;
  logic               head_rd_en;
  logic               head_wr_en;
  logic               ent_rd_en;
  logic [IW-1:0]      ent_rd_addr;
  logic               ent_wr_en;
  logic               fin;
  status_t            fin_status;
  logic [ROUTE_W-1:0] fin_route;
  logic               dflt_set;

  // octet sum stays below the default BUCKETS, so it is the bucket index as is
  assign req_sum    = SUM_W'(req.data.octet_a) + SUM_W'(req.data.octet_b)
                    + SUM_W'(req.data.octet_c);
  assign req_bucket = BW'(req_sum);
  assign accept     = req.valid && ready_c;
  assign out_free   = !out_valid || rsp.ready;
  assign pool_full  = (used == UW'(MAX_ENTRIES));

  assign head_valid     = head_rd_data[IW];
  assign head_idx       = head_rd_data[IW-1:0];
  assign ent_key        = ent_rd_data[EW-1 -: KEY_W];
  assign ent_value      = ent_rd_data[IW+ROUTE_W -: ROUTE_W];
  assign ent_link_valid = ent_rd_data[IW];
  assign ent_link_idx   = ent_rd_data[IW-1:0];
  assign walk_hit       = (ent_key == item_key);

  p24rt_head_mem #(
    .BUCKETS (BUCKETS),
    .IW      (IW)
  ) u_head (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (head_rd_en),
    .rd_addr (req_bucket),
    .rd_data (head_rd_data),
    .wr_en   (head_wr_en),
    .wr_addr (item_bucket),
    .wr_data ({1'b1, used[IW-1:0]}),
    .busy    (clearing)
  );

  p24rt_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .AW    (IW),
    .DW    (EW)
  ) u_entry (
    .clk     (clk),
    .rd_en   (ent_rd_en),
    .rd_addr (ent_rd_addr),
    .rd_data (ent_rd_data),
    .wr_en   (ent_wr_en),
    .wr_addr (used[IW-1:0]),
    .wr_data ({item_key, item_value, head_rd_data})
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (!clearing) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req.valid) begin
          state_next = S_HEAD;
        end
      end
      S_HEAD: begin
        if (item_lookup && head_valid) begin
          state_next = S_WALK;
        end else if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if ((walk_hit || !ent_link_valid) && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    ready_c     = 1'b0;
    head_rd_en  = 1'b0;
    head_wr_en  = 1'b0;
    ent_rd_en   = 1'b0;
    ent_rd_addr = head_idx;
    ent_wr_en   = 1'b0;
    fin         = 1'b0;
    fin_status  = default_valid ? STAT_DEFAULT : STAT_NOROUTE;
    fin_route   = default_valid ? default_route : '0;
    dflt_set    = 1'b0;
    case (state)
      S_IDLE: begin
        ready_c    = 1'b1;
        head_rd_en = req.valid;
      end
      S_HEAD: begin
        if (item_lookup) begin
          if (head_valid) begin
            ent_rd_en = 1'b1;
          end else begin
            fin = out_free;
          end
        end else if (out_free) begin
          fin       = 1'b1;
          fin_route = '0;
          if (pool_full) begin
            fin_status = STAT_FULL;
          end else begin
            fin_status = STAT_INSERTED;
            ent_wr_en  = 1'b1;
            head_wr_en = 1'b1;
            dflt_set   = (item_key == '0);
          end
        end
      end
      S_WALK: begin
        if (walk_hit) begin
          fin        = out_free;
          fin_status = STAT_MATCH;
          fin_route  = ent_value;
        end else if (ent_link_valid) begin
          // follow the chain
          ent_rd_en   = 1'b1;
          ent_rd_addr = ent_link_idx;
        end else begin
          fin = out_free;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      used          <= '0;
      default_valid <= 1'b0;
      default_route <= '0;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (ent_wr_en) begin
        used <= used + 1'b1;
      end
      if (dflt_set) begin
        default_valid <= 1'b1;
        default_route <= item_value;
      end
      if (fin) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_lookup <= (req.data.cmd == CMD_LOOKUP);
      item_key    <= {req.data.octet_a, req.data.octet_b, req.data.octet_c};
      item_value  <= req.data.route_value;
      item_bucket <= req_bucket;
    end
    if (fin) begin
      out_status <= fin_status;
      out_route  <= fin_route;
    end
  end

  assign req.ready          = ready_c;
  assign rsp.valid          = out_valid;
  assign rsp.data.status    = out_status;
  assign rsp.data.route_out = out_route;

  a_no_accept_while_clearing: assert property (
    @(posedge clk) disable iff (rst) clearing |-> !req.ready
  ) else $error("word accepted during head memory sweep");

  a_pool_bound: assert property (
    @(posedge clk) disable iff (rst) used <= UW'(MAX_ENTRIES)
  ) else $error("entry count beyond pool size");

  a_insert_writes_pair: assert property (
    @(posedge clk) disable iff (rst)
      ent_wr_en |-> (head_wr_en && !pool_full && !item_lookup)
  ) else $error("entry write without matching head write");

  a_default_after_zero: assert property (
    @(posedge clk) disable iff (rst)
      (ent_wr_en && item_key == '0) |=> (default_valid && default_route == $past(item_value))
  ) else $error("default route not taken from 0.0.0 insert");

  a_no_result_overwrite: assert property (
    @(posedge clk) disable iff (rst) fin |-> (!out_valid || rsp.ready)
  ) else $error("held result overwritten");

endmodule

[hdl/p24rt_head_mem.sv]
// Bucket head memory with a clearing sweep after reset.
module p24rt_head_mem #(
  parameter int BUCKETS = 1024,
  parameter int IW      = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [$clog2(BUCKETS)-1:0]   rd_addr,
  output logic [IW:0]                  rd_data,
  input  logic                         wr_en,
  input  logic [$clog2(BUCKETS)-1:0]   wr_addr,
  input  logic [IW:0]                  wr_data,
  output logic                         busy
);
  localparam int BW = $clog2(BUCKETS);

  logic [IW:0]   mem [BUCKETS];
  logic [BW-1:0] clr_addr;
  logic          mem_we;
  logic [BW-1:0] mem_wa;
  logic [IW:0]   mem_wd;

  // sweep every bucket to empty before taking traffic
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == BW'(BUCKETS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_comb begin
    if (busy) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_we = wr_en;
      mem_wa = wr_addr;
      mem_wd = wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[hdl/p24rt_entry_mem.sv]
// Entry pool memory: key, route and chain link per entry.
module p24rt_entry_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 49
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data
);
  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
